// File: design/sine_trajectory_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Sine trajectory generator assertion macros
// Shared property macros for the generator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SINE_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH
`define SINE_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define STG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sine trajectory generator assertion failed");

// next-cycle implication
`define STG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sine trajectory generator assertion failed");

`endif

// File: design/stg_pkg.sv
// ----------------------------------------------------------------------------
// Sine trajectory generator package
// Constants, register codes, cell bundle and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int SINE_TABLE_ADDR_BITS = 10;
  localparam int QTR_BITS = SINE_TABLE_ADDR_BITS - 2;
  localparam int QTR_SIZE = 1 << QTR_BITS;
  localparam int NUM_CELLS = 4;
  localparam int SLICE_BITS = 8;
  localparam longint unsigned PI_Q29 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic [2:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_FREQUENCY    = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_POS_UPPER    = 3'd3,
    REG_POS_LOWER    = 3'd4,
    REG_VEL_UPPER    = 3'd5,
    REG_VEL_LOWER    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic        vld;
    logic [31:0] tm;
    logic [31:0] frq;
    logic [31:0] acc;
  } cell_t;

  typedef logic [15:0] qsin_lut_t [QTR_SIZE+1];

  function automatic qsin_lut_t build_qsin_lut();
    qsin_lut_t       lut;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned t;
    longint unsigned s;
    for (int r = 0; r <= QTR_SIZE; r++) begin
      y  = (PI_Q29 * longint'(r)) >> QTR_BITS;
      y2 = (y * y) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 6;
      s  = (y * t) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      lut[r] = s[15:0];
    end
    return lut;
  endfunction

  localparam qsin_lut_t QSIN_LUT = build_qsin_lut();

endpackage

// File: design/sine_trajectory_generator_top.sv
// ----------------------------------------------------------------------------
// Sine trajectory generator
// An accepted request passes four phase cells and five math stages to done_o.
// Throughput: one request per cycle; busy_o stays low, results cannot stall.
// Each phase cell handles one 8-bit time slice.
// Reset clears valid flags and loads the default amplitude and bounds.
// ----------------------------------------------------------------------------
`include "sine_trajectory_generator_top_defines.svh"

module sine_trajectory_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [31:0]        elapsed_time_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [15:0] position_o,
  output logic signed [23:0] velocity_o,
  output logic               limit_exceeded_o
);

  localparam int NC = stg_pkg::NUM_CELLS;

  logic signed [15:0] amplitude_q;
  logic [23:0]        frequency_q;
  logic [15:0]        phase_offset_q;
  logic signed [15:0] pos_upper_q;
  logic signed [15:0] pos_lower_q;
  logic signed [23:0] vel_upper_q;
  logic signed [23:0] vel_lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q    <= '0;
      frequency_q    <= '0;
      phase_offset_q <= '0;
      pos_upper_q    <= 16'sh7fff;
      pos_lower_q    <= 16'sh8000;
      vel_upper_q    <= 24'sh7fffff;
      vel_lower_q    <= 24'sh800000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stg_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_wdata_i[15:0];
        stg_pkg::REG_FREQUENCY:    frequency_q    <= cfg_wdata_i;
        stg_pkg::REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata_i[15:0];
        stg_pkg::REG_POS_UPPER:    pos_upper_q    <= cfg_wdata_i[15:0];
        stg_pkg::REG_POS_LOWER:    pos_lower_q    <= cfg_wdata_i[15:0];
        stg_pkg::REG_VEL_UPPER:    vel_upper_q    <= cfg_wdata_i;
        stg_pkg::REG_VEL_LOWER:    vel_lower_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  stg_pkg::cell_t chain [NC+1];

  assign chain[0] = '{vld: start_i, tm: elapsed_time_i,
                      frq: {8'd0, frequency_q}, acc: {phase_offset_q, 16'd0}};

  for (genvar g = 0; g < NC; g++) begin : g_cell
    stg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  logic               trig_vld;
  logic signed [16:0] sin_v;
  logic signed [16:0] cos_v;

  stg_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (chain[NC].vld),
    .turn_i (chain[NC].acc),
    .vld_o  (trig_vld),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  // math stages b..e
  logic               vb_q, vc_q, vd_q, ve_q;
  logic signed [32:0] prod_pos_q;
  logic signed [32:0] prod_ac_q;
  logic signed [33:0] pos_sum;
  logic signed [18:0] pos_r;
  logic signed [15:0] pos_c_d;
  logic signed [15:0] pos_c_q;
  logic signed [15:0] pos_d_q;
  logic signed [57:0] pfull_q;
  logic signed [33:0] p_v;
  logic signed [65:0] vfull_q;
  logic signed [65:0] vel_sum;
  logic signed [30:0] vel_r;
  logic signed [23:0] vel_d;
  logic               flag_d;
  logic signed [15:0] position_q;
  logic signed [23:0] velocity_q;
  logic               limit_q;

  assign pos_sum = 34'(prod_pos_q) + 34'sd16384;
  assign pos_r   = pos_sum[33:15];

  always_comb begin
    if (pos_r > 19'sd32767) begin
      pos_c_d = 16'sh7fff;
    end else if (pos_r < -19'sd32768) begin
      pos_c_d = 16'sh8000;
    end else begin
      pos_c_d = pos_r[15:0];
    end
  end

  assign p_v     = pfull_q[57:24];
  assign vel_sum = vfull_q + (66'sd1 <<< 34);
  assign vel_r   = vel_sum[65:35];

  always_comb begin
    if (vel_r > 31'sd8388607) begin
      vel_d = 24'sh7fffff;
    end else if (vel_r < -31'sd8388608) begin
      vel_d = 24'sh800000;
    end else begin
      vel_d = vel_r[23:0];
    end
    flag_d = (pos_d_q > pos_upper_q) || (pos_d_q < pos_lower_q) ||
             (vel_d > vel_upper_q) || (vel_d < vel_lower_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      vb_q <= trig_vld;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_pos_q <= amplitude_q * sin_v;
    prod_ac_q  <= amplitude_q * cos_v;
    pos_c_q    <= pos_c_d;
    pfull_q    <= 58'(prod_ac_q) * 58'($signed({1'b0, frequency_q}));
    pos_d_q    <= pos_c_q;
    vfull_q    <= 66'(p_v) * 66'sd1686629713;
    position_q <= pos_d_q;
    velocity_q <= vel_d;
    limit_q    <= flag_d;
  end

  assign done_o           = ve_q;
  assign position_o       = position_q;
  assign velocity_o       = velocity_q;
  assign limit_exceeded_o = limit_q;

  `STG_ASSERT_IMPL(a_done_follows, start_i, ##9 done_o)
  `STG_ASSERT_IMPL(a_no_spurious, !start_i, ##9 !done_o)
  `STG_ASSERT_IMPL(a_pos_flag, done_o && (position_o > pos_upper_q), limit_exceeded_o)
  `STG_ASSERT_NEXT(a_busy_low, 1'b1, !busy_o)

endmodule

// File: design/stg_cell.sv
// ----------------------------------------------------------------------------
// Phase accumulation cell
// Add the product of frequency and one time slice, then shift both along.
// ----------------------------------------------------------------------------
module stg_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stg_pkg::cell_t cell_i,
  output stg_pkg::cell_t cell_o
);

  logic        vld_q;
  logic [31:0] tm_q;
  logic [31:0] frq_q;
  logic [31:0] acc_q;
  logic [39:0] prod;

  assign prod = cell_i.frq * cell_i.tm[stg_pkg::SLICE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tm_q  <= cell_i.tm >> stg_pkg::SLICE_BITS;
    frq_q <= cell_i.frq << stg_pkg::SLICE_BITS;
    acc_q <= cell_i.acc + prod[31:0];
  end

  assign cell_o = '{vld: vld_q, tm: tm_q, frq: frq_q, acc: acc_q};

endmodule

// File: design/stg_trig.sv
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// Fold the turn onto the quarter-wave table for sine and cosine.
// ----------------------------------------------------------------------------
module stg_trig (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [31:0]        turn_i,
  output logic               vld_o,
  output logic signed [16:0] sin_o,
  output logic signed [16:0] cos_o
);

  localparam int AB = stg_pkg::SINE_TABLE_ADDR_BITS;
  localparam int QB = stg_pkg::QTR_BITS;

  logic [AB-1:0]      ks;
  logic [AB-1:0]      kc;
  logic [QB:0]        rs;
  logic [QB:0]        rc;
  logic signed [16:0] sin_d;
  logic signed [16:0] cos_d;
  logic               vld_q;
  logic signed [16:0] sin_q;
  logic signed [16:0] cos_q;

  assign ks = turn_i[31 -: AB];
  assign kc = ks + AB'(stg_pkg::QTR_SIZE);

  always_comb begin
    rs = {1'b0, ks[QB-1:0]};
    if (ks[QB]) begin
      rs = (QB+1)'(stg_pkg::QTR_SIZE) - rs;
    end
    rc = {1'b0, kc[QB-1:0]};
    if (kc[QB]) begin
      rc = (QB+1)'(stg_pkg::QTR_SIZE) - rc;
    end
    sin_d = $signed({1'b0, stg_pkg::QSIN_LUT[rs]});
    cos_d = $signed({1'b0, stg_pkg::QSIN_LUT[rc]});
    if (ks[AB-1]) begin
      sin_d = -sin_d;
    end
    if (kc[AB-1]) begin
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign vld_o = vld_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
